/* sv/mmp_pkg.sv */
// Shared types, constants and modular helpers for the modular matrix power block.
package mmp_pkg;

    localparam int unsigned ELEM_W = 30;
    localparam int unsigned EXP_W  = 63;
    localparam int unsigned SIZE_W = 4;
    localparam int unsigned STEP_W = 5;
    localparam logic [ELEM_W:0] MODULUS = 31'd1000000007;

    typedef enum logic [3:0] {
        S_LOAD,
        S_INIT,
        S_CHECK,
        S_MM_RD,
        S_MM_START,
        S_MM_WAIT,
        S_CP_RD,
        S_CP_WR,
        S_OUT_RD,
        S_OUT_CAP,
        S_OUT_HOLD
    } state_t;

    function automatic logic [ELEM_W-1:0] mod_fold(input logic [ELEM_W:0] x);
        logic [ELEM_W:0] d;
        begin
            d = x - MODULUS;
            mod_fold = (x >= MODULUS) ? d[ELEM_W-1:0] : x[ELEM_W-1:0];
        end
    endfunction

    function automatic logic [ELEM_W-1:0] mod_add(input logic [ELEM_W-1:0] x,
                                                  input logic [ELEM_W-1:0] y);
        begin
            mod_add = mod_fold({1'b0, x} + {1'b0, y});
        end
    endfunction

endpackage

/* sv/mmp_if.sv */
// Handshake channel interfaces: input items, result items, size register writes.
interface mmp_item_if;
    logic                         valid;
    logic                         ready;
    logic [mmp_pkg::ELEM_W-1:0]   element;
    logic                         last_element;
    logic [mmp_pkg::EXP_W-1:0]    exponent;
    modport source (output valid, element, last_element, exponent, input ready);
    modport sink   (input valid, element, last_element, exponent, output ready);
endinterface

interface mmp_result_if;
    logic                         valid;
    logic                         ready;
    logic [mmp_pkg::ELEM_W-1:0]   result_element;
    logic                         last_result;
    modport source (output valid, result_element, last_result, input ready);
    modport sink   (input valid, result_element, last_result, output ready);
endinterface

interface mmp_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [mmp_pkg::SIZE_W-1:0]   size_in_use;
    modport source (output valid, size_in_use, input ready);
    modport sink   (input valid, size_in_use, output ready);
endinterface

/* sv/mmp_mac.sv */
// Bit-serial modular multiply-accumulate: result = (acc + a * b) mod 1000000007.
module mmp_mac (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [mmp_pkg::ELEM_W-1:0] a,
    input  logic [mmp_pkg::ELEM_W-1:0] b,
    input  logic [mmp_pkg::ELEM_W-1:0] acc,
    output logic                       done,
    output logic [mmp_pkg::ELEM_W-1:0] result
);

    logic                       busy_reg;
    logic                       done_reg;
    logic [mmp_pkg::STEP_W-1:0] cnt_reg;
    logic [mmp_pkg::ELEM_W-1:0] r_reg;
    logic [mmp_pkg::ELEM_W-1:0] a_reg;
    logic [mmp_pkg::ELEM_W-1:0] b_reg;
    logic [mmp_pkg::ELEM_W-1:0] acc_reg;
    logic [mmp_pkg::ELEM_W-1:0] dbl;
    logic [mmp_pkg::ELEM_W-1:0] r_next;

    always_comb
    begin
        dbl    = mmp_pkg::mod_fold({r_reg, 1'b0});
        r_next = a_reg[mmp_pkg::ELEM_W-1] ? mmp_pkg::mod_add(dbl, b_reg) : dbl;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == mmp_pkg::STEP_W'(mmp_pkg::ELEM_W))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            r_reg   <= '0;
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= acc;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == mmp_pkg::STEP_W'(mmp_pkg::ELEM_W))
            begin
                r_reg <= mmp_pkg::mod_add(r_reg, acc_reg);
            end
            else
            begin
                r_reg <= r_next;
                a_reg <= {a_reg[mmp_pkg::ELEM_W-2:0], 1'b0};
            end
        end
    end

    assign done   = done_reg;
    assign result = r_reg;

endmodule

/* sv/modular_matrix_power.sv */
// Modular matrix power top level: loads an n x n matrix, raises it to a power mod 1000000007.
// Entries are taken one per cycle in row-major order; the entry marked last carries the
// exponent and starts the work, during which no item is taken. Every product term goes
// through one bit-serial multiply-accumulate unit after an operand read and a start step.
// The power takes one identity fill, one squaring per exponent bit up to the highest set
// bit and one extra product per set bit. The result then leaves in row-major order, each
// entry read, captured and held until it is taken, the final entry marked.
module modular_matrix_power #(
    parameter int unsigned MAX_DIM = 8
) (
    input  logic clk,
    input  logic rst_n,
    mmp_item_if.sink     item,
    mmp_result_if.source result,
    mmp_cfg_if.sink      cfg
);

    localparam int unsigned CELLS  = MAX_DIM * MAX_DIM;
    localparam int unsigned IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int unsigned ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;

    mmp_pkg::state_t state_reg, state_next;

    logic [mmp_pkg::SIZE_W-1:0] size_reg;
    logic [IDX_W-1:0]           n_m1;
    logic [IDX_W-1:0]           r_reg, c_reg, k_reg;
    logic [IDX_W-1:0]           ld_r_reg, ld_c_reg;
    logic                       ld_full_reg;
    logic [mmp_pkg::EXP_W-1:0]  exp_reg;
    logic                       dst_a_reg;
    logic                       sq_reg;
    logic [mmp_pkg::ELEM_W-1:0] sum_reg;
    logic [mmp_pkg::ELEM_W-1:0] out_elem_reg;
    logic                       out_last_reg;

    logic [mmp_pkg::ELEM_W-1:0] a_mem [CELLS];
    logic [mmp_pkg::ELEM_W-1:0] p_mem [CELLS];
    logic [mmp_pkg::ELEM_W-1:0] t_mem [CELLS];
    logic [mmp_pkg::ELEM_W-1:0] a_q, p_x_q, p_y_q, t_q;

    logic [ADDR_W-1:0] a_rd_addr, rk_addr, kc_addr, rc_addr, ld_addr;

    logic item_xfer, result_xfer;
    logic mac_start, mac_done;
    logic [mmp_pkg::ELEM_W-1:0] mac_result;
    logic r_end, c_end, k_end, sweep_c_end, sweep_r_end;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [IDX_W-1:0] row,
                                                    input logic [IDX_W-1:0] col);
        begin
            cell_addr = ADDR_W'(row) * ADDR_W'(MAX_DIM) + ADDR_W'(col);
        end
    endfunction

    always_comb
    begin
        if (size_reg == '0)
            n_m1 = '0;
        else if (size_reg > mmp_pkg::SIZE_W'(MAX_DIM))
            n_m1 = IDX_W'(MAX_DIM - 1);
        else
            n_m1 = IDX_W'(size_reg - 1'b1);
    end

    assign rk_addr   = cell_addr(r_reg, k_reg);
    assign kc_addr   = cell_addr(k_reg, c_reg);
    assign rc_addr   = cell_addr(r_reg, c_reg);
    assign ld_addr   = cell_addr(ld_r_reg, ld_c_reg);
    assign a_rd_addr = (state_reg == mmp_pkg::S_OUT_RD) ? rc_addr : rk_addr;

    assign r_end       = (r_reg == n_m1);
    assign c_end       = (c_reg == n_m1);
    assign k_end       = (k_reg == n_m1);
    assign sweep_c_end = (c_reg == IDX_W'(MAX_DIM - 1));
    assign sweep_r_end = (r_reg == IDX_W'(MAX_DIM - 1));

    assign item_xfer   = item.valid && item.ready;
    assign result_xfer = result.valid && result.ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mmp_pkg::S_LOAD:
                if (item_xfer && item.last_element)
                    state_next = mmp_pkg::S_INIT;
            mmp_pkg::S_INIT:
                if (sweep_r_end && sweep_c_end)
                    state_next = mmp_pkg::S_CHECK;
            mmp_pkg::S_CHECK:
                state_next = (exp_reg == '0) ? mmp_pkg::S_OUT_RD : mmp_pkg::S_MM_RD;
            mmp_pkg::S_MM_RD:
                state_next = mmp_pkg::S_MM_START;
            mmp_pkg::S_MM_START:
                state_next = mmp_pkg::S_MM_WAIT;
            mmp_pkg::S_MM_WAIT:
                if (mac_done)
                    state_next = (k_end && c_end && r_end) ? mmp_pkg::S_CP_RD
                                                           : mmp_pkg::S_MM_RD;
            mmp_pkg::S_CP_RD:
                state_next = mmp_pkg::S_CP_WR;
            mmp_pkg::S_CP_WR:
                state_next = (sweep_r_end && sweep_c_end) ? mmp_pkg::S_CHECK
                                                          : mmp_pkg::S_CP_RD;
            mmp_pkg::S_OUT_RD:
                state_next = mmp_pkg::S_OUT_CAP;
            mmp_pkg::S_OUT_CAP:
                state_next = mmp_pkg::S_OUT_HOLD;
            mmp_pkg::S_OUT_HOLD:
                if (result_xfer)
                    state_next = out_last_reg ? mmp_pkg::S_LOAD : mmp_pkg::S_OUT_RD;
            default:
                state_next = mmp_pkg::S_LOAD;
        endcase
    end

    always_comb
    begin
        item.ready   = (state_reg == mmp_pkg::S_LOAD);
        result.valid = (state_reg == mmp_pkg::S_OUT_HOLD);
        mac_start    = (state_reg == mmp_pkg::S_MM_START);
        cfg.ready    = 1'b1;
    end

    assign result.result_element = out_elem_reg;
    assign result.last_result    = out_last_reg;

    mmp_mac u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mac_start),
        .a      (dst_a_reg ? a_q : p_x_q),
        .b      (p_y_q),
        .acc    (sum_reg),
        .done   (mac_done),
        .result (mac_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= mmp_pkg::S_LOAD;
            size_reg     <= mmp_pkg::SIZE_W'(8);
            r_reg        <= '0;
            c_reg        <= '0;
            k_reg        <= '0;
            ld_r_reg     <= '0;
            ld_c_reg     <= '0;
            ld_full_reg  <= 1'b0;
            exp_reg      <= '0;
            dst_a_reg    <= 1'b0;
            sq_reg       <= 1'b0;
            out_last_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg.valid && cfg.ready)
                size_reg <= cfg.size_in_use;
            unique case (state_reg)
                mmp_pkg::S_LOAD:
                    if (item_xfer)
                    begin
                        if (item.last_element)
                        begin
                            exp_reg     <= item.exponent;
                            ld_r_reg    <= '0;
                            ld_c_reg    <= '0;
                            ld_full_reg <= 1'b0;
                            r_reg       <= '0;
                            c_reg       <= '0;
                            k_reg       <= '0;
                            sq_reg      <= 1'b0;
                        end
                        else if (!ld_full_reg)
                        begin
                            if (ld_c_reg == n_m1)
                            begin
                                ld_c_reg <= '0;
                                if (ld_r_reg == n_m1)
                                    ld_full_reg <= 1'b1;
                                else
                                    ld_r_reg <= ld_r_reg + 1'b1;
                            end
                            else
                            begin
                                ld_c_reg <= ld_c_reg + 1'b1;
                            end
                        end
                    end
                mmp_pkg::S_INIT, mmp_pkg::S_CP_WR:
                begin
                    if (sweep_c_end)
                    begin
                        c_reg <= '0;
                        r_reg <= sweep_r_end ? '0 : r_reg + 1'b1;
                    end
                    else
                    begin
                        c_reg <= c_reg + 1'b1;
                    end
                    if (state_reg == mmp_pkg::S_CP_WR && sweep_c_end && sweep_r_end)
                    begin
                        if (dst_a_reg)
                        begin
                            sq_reg <= 1'b1;
                        end
                        else
                        begin
                            sq_reg  <= 1'b0;
                            exp_reg <= exp_reg >> 1;
                        end
                    end
                end
                mmp_pkg::S_CHECK:
                begin
                    dst_a_reg <= !sq_reg && exp_reg[0];
                    k_reg     <= '0;
                end
                mmp_pkg::S_MM_WAIT:
                    if (mac_done)
                    begin
                        if (k_end)
                        begin
                            k_reg <= '0;
                            if (c_end)
                            begin
                                c_reg <= '0;
                                r_reg <= r_end ? '0 : r_reg + 1'b1;
                            end
                            else
                            begin
                                c_reg <= c_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            k_reg <= k_reg + 1'b1;
                        end
                    end
                mmp_pkg::S_OUT_CAP:
                    out_last_reg <= r_end && c_end;
                mmp_pkg::S_OUT_HOLD:
                    if (result_xfer)
                    begin
                        if (c_end)
                        begin
                            c_reg <= '0;
                            r_reg <= r_end ? '0 : r_reg + 1'b1;
                        end
                        else
                        begin
                            c_reg <= c_reg + 1'b1;
                        end
                    end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == mmp_pkg::S_CHECK ||
            (state_reg == mmp_pkg::S_MM_WAIT && mac_done && k_end))
            sum_reg <= '0;
        else if (state_reg == mmp_pkg::S_MM_WAIT && mac_done)
            sum_reg <= mac_result;
        if (state_reg == mmp_pkg::S_OUT_CAP)
            out_elem_reg <= a_q;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == mmp_pkg::S_LOAD && item_xfer && !ld_full_reg)
            p_mem[ld_addr] <= mmp_pkg::mod_fold({1'b0, item.element});
        else if (state_reg == mmp_pkg::S_CP_WR && !dst_a_reg)
            p_mem[rc_addr] <= t_q;
        p_x_q <= p_mem[rk_addr];
        p_y_q <= p_mem[kc_addr];
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == mmp_pkg::S_INIT)
            a_mem[rc_addr] <= (r_reg == c_reg) ? mmp_pkg::ELEM_W'(1) : '0;
        else if (state_reg == mmp_pkg::S_CP_WR && dst_a_reg)
            a_mem[rc_addr] <= t_q;
        a_q <= a_mem[a_rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == mmp_pkg::S_MM_WAIT && mac_done && k_end)
            t_mem[rc_addr] <= mac_result;
        t_q <= t_mem[rc_addr];
    end

endmodule

/* sv/mmp_checker.sv */
// Port-level checker for the modular matrix power block, bound to the top level.
module mmp_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       item_valid,
    input logic                       item_ready,
    input logic                       item_last,
    input logic                       result_valid,
    input logic                       result_ready,
    input logic                       result_last,
    input logic [mmp_pkg::ELEM_W-1:0] result_element
);

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result_element)
                                          && $stable(result_last))
        else $error("stalled result changed");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(item_ready && result_valid))
        else $error("loading and emitting at once");

    a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && item_last |=> !item_ready && !result_valid)
        else $error("not busy after last entry");

    a_end_of_result: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_ready && result_last |=> !result_valid && item_ready)
        else $error("result continued past last entry");

endmodule

bind modular_matrix_power mmp_checker u_mmp_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .item_valid     (item.valid),
    .item_ready     (item.ready),
    .item_last      (item.last_element),
    .result_valid   (result.valid),
    .result_ready   (result.ready),
    .result_last    (result.last_result),
    .result_element (result.result_element)
);

/* tb/mmp_checker.sv */
// Checker for the modular matrix power block: tracks the size register, predicts results, compares.
module mmp_scoreboard (
    input  logic   clk,
    input  logic   rst_n,
    mmp_item_if    item,
    mmp_result_if  result,
    mmp_cfg_if     cfg,
    output int     errors,
    output int     outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned GRID_DIM = 8;
    localparam int unsigned CELLS = GRID_DIM * GRID_DIM;
    localparam longint unsigned PRIME = 64'd1000000007;

    typedef logic [mmp_pkg::ELEM_W-1:0] grid_t [CELLS];

    typedef struct packed {
        logic [mmp_pkg::ELEM_W-1:0] value;
        logic                       last;
    } entry_t;

    entry_t                     entries_due[$];
    grid_t                      base_grid;
    logic [mmp_pkg::SIZE_W-1:0] size_reg;
    int unsigned                load_pos;

    function automatic int unsigned dim_of(logic [mmp_pkg::SIZE_W-1:0] s);
        if (s == 0)
            return 1;
        if (s > GRID_DIM)
            return GRID_DIM;
        return 32'(s);
    endfunction

    function automatic grid_t grid_mul(grid_t x, grid_t y, int unsigned n);
        grid_t           p;
        longint unsigned acc;
        for (int i = 0; i < CELLS; i++)
            p[i] = '0;
        for (int r = 0; r < n; r++)
            for (int c = 0; c < n; c++)
            begin
                acc = 0;
                for (int k = 0; k < n; k++)
                    acc = (acc + longint'(x[r*GRID_DIM+k]) * longint'(y[k*GRID_DIM+c])) % PRIME;
                p[r*GRID_DIM+c] = acc[mmp_pkg::ELEM_W-1:0];
            end
        return p;
    endfunction

    task automatic predict_power(logic [mmp_pkg::EXP_W-1:0] power, int unsigned n);
        grid_t                     running;
        grid_t                     square;
        logic [mmp_pkg::EXP_W-1:0] e;
        entry_t                    ent;
        square = base_grid;
        for (int i = 0; i < CELLS; i++)
            running[i] = '0;
        for (int r = 0; r < n; r++)
            running[r*GRID_DIM+r] = mmp_pkg::ELEM_W'(1);
        e = power;
        while (e != 0)
        begin
            if (e[0])
                running = grid_mul(running, square, n);
            square = grid_mul(square, square, n);
            e = e >> 1;
        end
        for (int r = 0; r < n; r++)
            for (int c = 0; c < n; c++)
            begin
                ent.value = running[r*GRID_DIM+c];
                ent.last  = (r == n - 1) && (c == n - 1);
                entries_due.push_back(ent);
            end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        int unsigned     n;
        entry_t          want;
        longint unsigned raw;
        longint unsigned folded;
        if (!rst_n)
        begin
            size_reg = 4'd8;
            load_pos = 0;
            for (int i = 0; i < CELLS; i++)
                base_grid[i] = '0;
            entries_due.delete();
            errors = 0;
            outstanding = 0;
        end
        else
        begin
            if (result.valid && result.ready)
            begin
                if (entries_due.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result: actual element %0d last %0b",
                             $time, result.result_element, result.last_result);
                end
                else
                begin
                    want = entries_due.pop_front();
                    if (want.value !== result.result_element)
                    begin
                        errors++;
                        $display("%0t: result_element mismatch: expected %0d actual %0d",
                                 $time, want.value, result.result_element);
                    end
                    if (want.last !== result.last_result)
                    begin
                        errors++;
                        $display("%0t: last_result mismatch: expected %0b actual %0b",
                                 $time, want.last, result.last_result);
                    end
                end
            end
            if (cfg.valid && cfg.ready)
                size_reg = cfg.size_in_use;
            if (item.valid && item.ready)
            begin
                n = dim_of(size_reg);
                if (load_pos < n * n)
                begin
                    raw = 64'(item.element);
                    folded = raw % PRIME;
                    base_grid[(load_pos / n) * GRID_DIM + load_pos % n] =
                        folded[mmp_pkg::ELEM_W-1:0];
                    load_pos++;
                end
                if (item.last_element)
                begin
                    predict_power(item.exponent, n);
                    load_pos = 0;
                end
            end
            outstanding = entries_due.size();
        end
    end

endmodule

/* tb/tb_modular_matrix_power.sv */
// Testbench top for the modular matrix power block: clock, reset, stimulus, watchdog and verdict.
module tb_modular_matrix_power;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 300000;
    localparam int LONG_HOLD = 2000;
    localparam logic [mmp_pkg::ELEM_W-1:0] TOP_RESIDUE = 30'd1000000006;

    logic clk;
    logic rst_n;
    int   errors;
    int   outstanding;
    int   tx_idle;
    int   rx_idle;
    int   hold_left;
    bit   hold_req;
    int   quiet_cycles;
    int   items_sent;
    int   matrices_sent;

    mmp_item_if   item_ch ();
    mmp_result_if result_ch ();
    mmp_cfg_if    cfg_ch ();

    modular_matrix_power #(.MAX_DIM(8)) DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    mmp_scoreboard u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (item_ch),
        .result      (result_ch),
        .cfg         (cfg_ch),
        .errors      (errors),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            result_ch.ready <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            result_ch.ready <= 1'b0;
        end
        else if (hold_req)
        begin
            hold_left <= LONG_HOLD;
            result_ch.ready <= 1'b0;
        end
        else
            result_ch.ready <= ($urandom_range(99) >= rx_idle);
    end

    always @(posedge clk)
    begin
        if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: watchdog expired, %0d results still due", $time, outstanding);
            $display("tb_modular_matrix_power: FAIL");
            $finish;
        end
    end

    function automatic logic [mmp_pkg::EXP_W-1:0] rand_exp(int bits);
        logic [63:0] v;
        v = {$urandom, $urandom};
        if (bits == 0)
            return '0;
        if (bits < 64)
            v = v & ((64'd1 << bits) - 64'd1);
        v[bits-1] = 1'b1;
        return v[mmp_pkg::EXP_W-1:0];
    endfunction

    function automatic logic [mmp_pkg::EXP_W-1:0] pick_exp(int n);
        int maxbits;
        if (n == 1)
            maxbits = ($urandom_range(4) == 0) ? 63 : 12;
        else if (n == 2)
            maxbits = 10;
        else if (n == 3)
            maxbits = 6;
        else if (n == 4)
            maxbits = 4;
        else
            maxbits = 2;
        return rand_exp(int'($urandom_range(maxbits, 0)));
    endfunction

    function automatic logic [mmp_pkg::ELEM_W-1:0] rand_elem();
        if ($urandom_range(9) == 0)
            return mmp_pkg::ELEM_W'($urandom_range(30'h3FFF_FFFF, 1000000007));
        return mmp_pkg::ELEM_W'($urandom_range(TOP_RESIDUE, 0));
    endfunction

    task automatic send_item(logic [mmp_pkg::ELEM_W-1:0] el, logic lst,
                             logic [mmp_pkg::EXP_W-1:0] ex);
        while ($urandom_range(99) < tx_idle)
        begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid        <= 1'b1;
        item_ch.element      <= el;
        item_ch.last_element <= lst;
        item_ch.exponent     <= ex;
        do @(negedge clk); while (!item_ch.ready);
        @(posedge clk);
        items_sent++;
    endtask

    task automatic send_matrix(int n, logic [mmp_pkg::EXP_W-1:0] power, int extra);
        int  count;
        bit  lst;
        count = n * n + extra;
        for (int i = 0; i < count; i++)
        begin
            lst = (i == count - 1);
            send_item(rand_elem(), lst, lst ? power : rand_exp(63));
        end
        matrices_sent++;
    endtask

    task automatic run_random(int n, int target);
        int count;
        int extra;
        count = 0;
        while (count < target)
        begin
            extra = ($urandom_range(15) == 0) ? $urandom_range(2, 1) : 0;
            send_matrix(n, pick_exp(n), extra);
            count += n * n + extra;
        end
    endtask

    task automatic wait_idle();
        item_ch.valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_size(logic [mmp_pkg::SIZE_W-1:0] value);
        wait_idle();
        cfg_ch.valid       <= 1'b1;
        cfg_ch.size_in_use <= value;
        do @(negedge clk); while (!cfg_ch.ready);
        @(posedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    initial
    begin
        rst_n                <= 1'b0;
        item_ch.valid        <= 1'b0;
        item_ch.element      <= '0;
        item_ch.last_element <= 1'b0;
        item_ch.exponent     <= '0;
        cfg_ch.valid         <= 1'b0;
        cfg_ch.size_in_use   <= '0;
        hold_req      = 1'b0;
        items_sent    = 0;
        matrices_sent = 0;
        tx_idle       = 25;
        rx_idle       = 80;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // size zero acts as one
        write_size(4'd0);
        send_item('0, 1'b1, '0);
        send_item(TOP_RESIDUE, 1'b1, {mmp_pkg::EXP_W{1'b1}});
        send_item(30'h3FFF_FFFF, 1'b1, 63'd5);
        send_item(30'd7, 1'b0, '0);
        send_item(30'd9, 1'b0, {mmp_pkg::EXP_W{1'b1}});
        send_item(30'd11, 1'b1, 63'd3);
        write_size(4'd2);
        for (int i = 0; i < 4; i++)
            send_item(TOP_RESIDUE, i == 3, 63'd1);
        for (int i = 0; i < 4; i++)
            send_item(rand_elem(), i == 3, '0);
        run_random(2, 16);
        write_size(4'd3);
        run_random(3, 18);
        write_size(4'd1);
        run_random(1, 25);

        tx_idle = 80;
        rx_idle = 25;
        // size above the maximum acts as the maximum
        write_size(4'd15);
        send_matrix(8, '0, 0);
        send_matrix(8, 63'd1, 0);
        write_size(4'd1);
        hold_req = 1'b1;
        @(posedge clk);
        @(posedge clk);
        hold_req = 1'b0;
        run_random(1, 12);
        write_size(4'd4);
        run_random(4, 32);

        tx_idle = 0;
        rx_idle = 0;
        write_size(4'd8);
        send_matrix(8, 63'd2, 0);
        write_size(4'd5);
        run_random(5, 25);
        write_size(4'd6);
        run_random(6, 36);
        write_size(4'd7);
        run_random(7, 49);
        write_size(4'd2);
        run_random(2, 8);
        write_size(4'd3);
        run_random(3, 18);

        wait_idle();
        repeat (50) @(posedge clk);
        $display("Covered %0d input transfers in %0d matrices, sizes 1 through 8 plus 0 and 15,",
                 items_sent, matrices_sent);
        $display("exponents from zero to full width, overlong matrices and a long output stall.");
        if (errors == 0 && outstanding == 0)
            $display("tb_modular_matrix_power: PASS");
        else
            $display("tb_modular_matrix_power: FAIL");
        $finish;
    end

endmodule
